@@ design/ncwr_pkg.sv @@
// Shared types and constants for the nearest circle search unit.
`default_nettype none
package ncwr_pkg;

    localparam int SLOT_W  = 6;
    localparam int ID_W    = 16;
    localparam int POS_W   = 16;
    localparam int RAD_W   = 15;
    localparam int DIST_W  = 17;
    localparam int DIFF_W  = 17;
    localparam int SQ_W    = 33;
    localparam int SUM_W   = 18;
    localparam int RR_W    = 36;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;
    localparam logic [DIST_W-1:0] BOUND_MAX = 17'd92682;

    // One stored circle.
    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [RAD_W-1:0]        rad;
    } entry_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic                    is_query;
        logic                    do_store;
        logic                    do_clear;
        logic                    asker_chk;
        logic [SLOT_W-1:0]       slot;
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [RAD_W-1:0]        rad;
    } item_t;

endpackage
`default_nettype wire

@@ design/ncwr_front.sv @@
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none
module ncwr_front #(
    parameter int DEPTH          = 64,
    parameter int MAX_ENTITY_IDS = 65536
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ncwr_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic [0:0]                          s_tuser,
    output logic                                     q_valid,
    input  wire logic                                q_ready,
    output ncwr_pkg::item_t                          q_item
);

    ncwr_pkg::item_t             cls;
    ncwr_pkg::item_t             fifo_reg [2];
    logic                        wr_ptr_reg, wr_ptr_next;
    logic                        rd_ptr_reg, rd_ptr_next;
    logic [1:0]                  count_reg, count_next;
    logic                        push, pop, id_ok, slot_ok;

    // Decode the beat and work out which table action it calls for.
    always_comb begin
        cls.is_query = s_tuser[0];
        cls.slot     = s_tdata[5:0];
        cls.id       = s_tdata[21:6];
        cls.x        = s_tdata[37:22];
        cls.y        = s_tdata[53:38];
        cls.rad      = s_tdata[68:54];
        id_ok        = {1'b0, cls.id} < 17'(MAX_ENTITY_IDS);
        slot_ok      = {1'b0, cls.slot} < 7'(DEPTH);
        cls.do_store = !cls.is_query && slot_ok && id_ok && (cls.id != '0);
        cls.do_clear = !cls.is_query && slot_ok && id_ok && (cls.id == '0);
        cls.asker_chk = id_ok;
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = fifo_reg[rd_ptr_reg];

    // Queue pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

@@ design/ncwr_root.sv @@
// Iterative floor square root, two radicand bits per cycle.
`default_nettype none
module ncwr_root (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [ncwr_pkg::SQ_W-1:0]     value,
    output logic                               busy,
    output logic                               done,
    output logic [ncwr_pkg::DIST_W-1:0]        root
);

    logic [33:0]                    rad_reg, rad_next;
    logic [18:0]                    rem_reg, rem_next;
    logic [ncwr_pkg::DIST_W-1:0]    root_reg, root_next;
    logic [4:0]                     cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [19:0]                    rem_sh, trial;

    // One digit of the restoring root per cycle.
    always_comb begin
        rem_sh    = {rem_reg[17:0], rad_reg[33:32]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = {1'b0, value};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd17;
        end else if (cnt_reg != 5'd0) begin
            rad_next = {rad_reg[31:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = 19'(rem_sh - trial);
                root_next = {root_reg[15:0], 1'b1};
            end else begin
                rem_next  = rem_sh[18:0];
                root_next = {root_reg[15:0], 1'b0};
            end
            cnt_next  = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (cnt_reg != 5'd0);
    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

@@ design/ncwr_back.sv @@
// Back end: object table, slot scan sequencer and result register.
`default_nettype none
module ncwr_back #(
    parameter int DEPTH = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_valid,
    output logic                                    q_ready,
    input  wire ncwr_pkg::item_t                    q_item,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [ncwr_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic [0:0]                              m_tuser
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_LOAD = 8'b0000_0100,
        S_SQR  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_ROOT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t                              state_reg, state_next;
    ncwr_pkg::entry_t                    mem [DEPTH];
    ncwr_pkg::entry_t                    rd_reg;
    logic [DEPTH-1:0]                    valid_reg, valid_next;
    logic [CNT_W-1:0]                    idx_reg, idx_next;
    logic [IDX_W-1:0]                    idx;
    ncwr_pkg::item_t                     qry_reg, qry_next;
    logic [ncwr_pkg::DIST_W-1:0]         bound_reg, bound_next;
    logic                                hit_reg, hit_next;
    logic [ncwr_pkg::SLOT_W-1:0]         hslot_reg, hslot_next;
    logic [ncwr_pkg::ID_W-1:0]           hid_reg, hid_next;
    logic signed [ncwr_pkg::DIFF_W-1:0]  dx_reg, dy_reg, dx_next, dy_next;
    logic [ncwr_pkg::RAD_W-1:0]          orad_reg, orad_next;
    logic [ncwr_pkg::ID_W-1:0]           oid_reg, oid_next;
    logic [ncwr_pkg::SQ_W-1:0]           sqx_reg, sqy_reg, d2_reg;
    logic signed [33:0]                  px, py;
    logic [ncwr_pkg::SUM_W-1:0]          r_reg;
    logic [ncwr_pkg::RR_W-1:0]           rr_reg;
    logic                                mem_we;
    logic                                root_start, root_busy, root_done;
    logic [ncwr_pkg::DIST_W-1:0]         root_val;
    logic                                out_valid_reg, out_valid_next, out_load;
    logic [ncwr_pkg::OUT_TDATA_W-1:0]    out_data_reg;
    logic                                out_found_reg;

    assign idx = idx_reg[IDX_W-1:0];

    // Widened signed difference of two positions.
    function automatic logic signed [ncwr_pkg::DIFF_W-1:0] DIFF_W_SUB(
        input logic signed [ncwr_pkg::POS_W-1:0] a,
        input logic signed [ncwr_pkg::POS_W-1:0] b
    );
        DIFF_W_SUB = {a[15], a} - {b[15], b};
    endfunction

    ncwr_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .value   (d2_reg),
        .busy    (root_busy),
        .done    (root_done),
        .root    (root_val)
    );

    // Scan sequencer.
    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        qry_next   = qry_reg;
        bound_next = bound_reg;
        hit_next   = hit_reg;
        hslot_next = hslot_reg;
        hid_next   = hid_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        orad_next  = orad_reg;
        oid_next   = oid_reg;
        q_ready    = 1'b0;
        mem_we     = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    qry_next   = q_item;
                    hit_next   = 1'b0;
                    hslot_next = '0;
                    hid_next   = '0;
                    bound_next = {2'b00, q_item.rad};
                    idx_next   = '0;
                    if (q_item.is_query) begin
                        state_next = S_READ;
                    end else begin
                        mem_we = q_item.do_store;
                        if (q_item.do_store) begin
                            valid_next[q_item.slot[IDX_W-1:0]] = 1'b1;
                        end
                        if (q_item.do_clear) begin
                            valid_next[q_item.slot[IDX_W-1:0]] = 1'b0;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_READ: begin
                if (idx_reg == CNT_W'(DEPTH)) begin
                    state_next = S_DONE;
                end else if (valid_reg[idx]) begin
                    state_next = S_LOAD;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_LOAD: begin
                if (qry_reg.asker_chk && (rd_reg.id == qry_reg.id)) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end else begin
                    dx_next    = DIFF_W_SUB(rd_reg.x, qry_reg.x);
                    dy_next    = DIFF_W_SUB(rd_reg.y, qry_reg.y);
                    orad_next  = rd_reg.rad;
                    oid_next   = rd_reg.id;
                    state_next = S_SQR;
                end
            end
            S_SQR: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if ({3'b000, d2_reg} < rr_reg) begin
                    root_start = 1'b1;
                    state_next = S_ROOT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_ROOT: begin
                if (root_done) begin
                    bound_next = root_val;
                    hit_next   = 1'b1;
                    hslot_next = ncwr_pkg::SLOT_W'(idx);
                    hid_next   = oid_reg;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath: differences, squares, threshold square, sums.
    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        qry_reg   <= qry_next;
        bound_reg <= bound_next;
        hit_reg   <= hit_next;
        hslot_reg <= hslot_next;
        hid_reg   <= hid_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        orad_reg  <= orad_next;
        oid_reg   <= oid_next;
        sqx_reg   <= px[32:0];
        sqy_reg   <= py[32:0];
        r_reg     <= {1'b0, bound_reg} + {3'b000, orad_reg};
        d2_reg    <= sqx_reg + sqy_reg;
        rr_reg    <= r_reg * r_reg;
    end

    // Object table, one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[q_item.slot[IDX_W-1:0]] <= '{id: q_item.id, x: q_item.x,
                                            y: q_item.y, rad: q_item.rad};
        end
        rd_reg <= mem[idx];
    end

    // Result register: one beat waits here while the next item is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_found_reg <= hit_reg;
            out_data_reg  <= {1'b0, (hit_reg ? bound_reg : 17'd0), hid_reg, hslot_reg};
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_found_reg;

`ifndef SYNTHESIS
    // The root wait state always has the root unit running or finishing.
    a_root_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROOT) |-> (root_busy || root_done))
        else $error("root wait without active root unit");

    // The search bound never grows past BOUND_MAX, the package bound on the root.
    a_bound_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (bound_reg <= ncwr_pkg::BOUND_MAX))
        else $error("search bound out of range");

    // The scan index never passes the table depth.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (idx_reg <= CNT_W'(DEPTH)))
        else $error("scan index out of range");

    // A hit is only ever recorded during a query.
    a_hit_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && hit_reg) |-> qry_reg.is_query)
        else $error("hit reported for a write item");
`endif

endmodule
`default_nettype wire

@@ design/nearest_circle_within_radius_unit.sv @@
// A write passes from the idle state straight to the done state, which loads the result register.
// A query scans every slot: an empty slot passes the read state only, a slot of the asker
// also the load state, any other occupied slot read, load, square, multiply and compare,
// and a hit also waits for the bit-serial square root. Items are worked one at a time
// by the scan sequencer; a two-beat queue and a result register decouple both sides.
// Synchronous active-low reset clears the valid marks, queue and control state; table contents are kept.
`default_nettype none
module nearest_circle_within_radius_unit #(
    parameter int MAX_OBJECTS    = 64,
    parameter int MAX_ENTITY_IDS = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // slot[5:0], entity_id[21:6], pos_x[37:22], pos_y[53:38], radius[68:54], zero pad
    input  wire logic [71:0] s_tdata,
    // operation[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // found_slot[5:0], found_entity[21:6], found_distance[38:22], zero pad
    output logic [39:0]      m_tdata,
    // found[0]
    output logic [0:0]       m_tuser
);

    localparam int DEPTH = (MAX_OBJECTS < 64) ? MAX_OBJECTS : 64;

    logic            q_valid, q_ready;
    ncwr_pkg::item_t q_item;

    ncwr_front #(
        .DEPTH          (DEPTH),
        .MAX_ENTITY_IDS (MAX_ENTITY_IDS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    ncwr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

@@ tb/nearest_circle_within_radius_unit_checker.sv @@
// Watches both channels of the nearest circle unit, predicts each answer and compares.
`default_nettype none
module nearest_circle_within_radius_unit_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic [0:0]  m_tuser,
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        logic                        found;
        logic [ncwr_pkg::SLOT_W-1:0] slot;
        logic [ncwr_pkg::ID_W-1:0]   entity;
        logic [ncwr_pkg::DIST_W-1:0] distance;
    } answer_t;

    ncwr_pkg::entry_t circles [64];
    logic             occupied [64];
    answer_t          answers_due [$];

    assign pending_count = answers_due.size();

    // Floor square root, bit by bit.
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Applies one input beat to the shadow table and returns the expected answer.
    function automatic answer_t nearest_answer(logic is_query, logic [71:0] d);
        answer_t a;
        logic [ncwr_pkg::SLOT_W-1:0] sl;
        logic [ncwr_pkg::ID_W-1:0] id;
        longint qx, qy, dx, dy;
        longint unsigned bound, d2, r;
        logic [ncwr_pkg::RAD_W-1:0] rad;
        a = '0;
        sl = d[5:0];
        id = d[21:6];
        qx = $signed(d[37:22]);
        qy = $signed(d[53:38]);
        rad = d[68:54];
        if (!is_query) begin
            if (id == 0) begin
                occupied[sl] = 1'b0;
            end else begin
                circles[sl] = '{id: id, x: d[37:22], y: d[53:38], rad: rad};
                occupied[sl] = 1'b1;
            end
            return a;
        end
        bound = rad;
        for (int i = 0; i < 64; i++) begin
            if (occupied[i] && circles[i].id != id) begin
                dx = longint'(circles[i].x) - qx;
                dy = longint'(circles[i].y) - qy;
                d2 = dx * dx + dy * dy;
                r = bound + circles[i].rad;
                if (d2 < r * r) begin
                    bound = isqrt(d2);
                    a = '{found: 1'b1, slot: i[5:0], entity: circles[i].id,
                          distance: bound[ncwr_pkg::DIST_W-1:0]};
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Predict on input beats, compare on result beats.
    always @(posedge aclk) begin
        answer_t e;
        if (!aresetn) begin
            fail_count = 0;
            for (int i = 0; i < 64; i++) occupied[i] = 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                answers_due.push_back(nearest_answer(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    e = answers_due.pop_front();
                    if (m_tuser[0] !== e.found) report_mismatch("found", m_tuser[0], e.found);
                    if (m_tdata[5:0] !== e.slot) report_mismatch("slot", m_tdata[5:0], e.slot);
                    if (m_tdata[21:6] !== e.entity)
                        report_mismatch("entity", m_tdata[21:6], e.entity);
                    if (m_tdata[38:22] !== e.distance)
                        report_mismatch("distance", m_tdata[38:22], e.distance);
                    if (m_tdata[39] !== 1'b0) report_mismatch("pad", m_tdata[39], 0);
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ tb/nearest_circle_within_radius_unit_tb.sv @@
// Stimulus and verdict for the nearest circle unit testbench.
`default_nettype none
module nearest_circle_within_radius_unit_tb;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam int   CYCLE_LIMIT = 12000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycle_count = 0;
    logic [15:0] known_ids [8];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    nearest_circle_within_radius_unit u_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    nearest_circle_within_radius_unit_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .fail_count, .pending_count
    );

    // Receiver stalls at random.
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Run watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nearest_circle_within_radius_unit_tb failed");
            $finish;
        end
    end

    // Sends one beat, with optional idle cycles first.
    task automatic send_beat(logic op, logic [5:0] sl, logic [15:0] id,
                             logic [15:0] x, logic [15:0] y, logic [14:0] rad);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, rad, y, x, id, sl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Positions clustered near a point so that searches find something.
    function automatic logic [15:0] near_pos(logic [15:0] c);
        return c + 16'($signed($urandom_range(16383)) - 8192);
    endfunction

    task automatic random_items(int n);
        logic [15:0] cx, cy;
        int k;
        cx = 16'($urandom);
        cy = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 4)
                send_beat(OP_WRITE, 6'($urandom), 16'd0, 16'($urandom), 16'($urandom),
                          15'($urandom));
            else if (k < 45)
                send_beat(OP_WRITE, 6'($urandom), known_ids[$urandom_range(7)],
                          near_pos(cx), near_pos(cy), 15'($urandom_range(4095)));
            else if (k < 50)
                send_beat(OP_WRITE, 6'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 15'($urandom));
            else if (k < 90)
                send_beat(OP_QUERY, 6'($urandom),
                          ($urandom_range(3) == 0) ? 16'($urandom) :
                          known_ids[$urandom_range(7)],
                          near_pos(cx), near_pos(cy), 15'($urandom_range(8191)));
            else
                send_beat(OP_QUERY, 6'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 15'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) known_ids[i] = 16'($urandom_range(65535, 1));
        known_ids[7] = 16'hFFFF;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, extremes, asker skip, clears, growing bound.
        send_beat(OP_QUERY, 6'd0, 16'd0, 16'h0000, 16'h0000, 15'h7FFF);
        send_beat(OP_WRITE, 6'd0, 16'd1, 16'h8000, 16'h8000, 15'h7FFF);
        send_beat(OP_WRITE, 6'd63, 16'hFFFF, 16'h7FFF, 16'h7FFF, 15'h7FFF);
        send_beat(OP_QUERY, 6'd63, 16'd0, 16'h7FFF, 16'h8000, 15'h7FFF);
        send_beat(OP_QUERY, 6'd0, 16'hFFFF, 16'h8000, 16'h8000, 15'h0000);
        send_beat(OP_QUERY, 6'd0, 16'd1, 16'h8000, 16'h8000, 15'h0000);
        send_beat(OP_WRITE, 6'd5, 16'd7, 16'h0100, 16'h0000, 15'h0010);
        send_beat(OP_WRITE, 6'd6, 16'd8, 16'h0300, 16'h0000, 15'h0800);
        send_beat(OP_WRITE, 6'd7, 16'd9, 16'h0000, 16'h0000, 15'h0000);
        send_beat(OP_QUERY, 6'd21, 16'd2, 16'h0000, 16'h0000, 15'h0200);
        send_beat(OP_QUERY, 6'd42, 16'd9, 16'h0000, 16'h0000, 15'h0000);
        send_beat(OP_QUERY, 6'd0, 16'd7, 16'h0000, 16'h0000, 15'h0001);
        send_beat(OP_WRITE, 6'd6, 16'd0, 16'h1234, 16'h5678, 15'h1234);
        send_beat(OP_QUERY, 6'd0, 16'd3, 16'h0000, 16'h0000, 15'h7FFF);
        send_beat(OP_WRITE, 6'd0, 16'd0, 16'h0000, 16'h0000, 15'h0000);
        send_beat(OP_WRITE, 6'd63, 16'd0, 16'hFFFF, 16'hFFFF, 15'h7FFF);
        send_beat(OP_QUERY, 6'd0, 16'd0, 16'hFFFF, 16'hFFFF, 15'h7FFF);

        // Random phases with different idling.
        random_items(500);
        send_idle_pct = 65;
        random_items(450);
        send_idle_pct = 0;
        recv_stall_pct = 65;
        random_items(450);
        send_idle_pct = 14;
        recv_stall_pct = 14;
        random_items(500);
        s_tvalid <= 1'b0;

        recv_stall_pct = 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("nearest_circle_within_radius_unit_tb passed");
        else
            $display("nearest_circle_within_radius_unit_tb failed");
        $finish;
    end

endmodule
`default_nettype wire
